/* rtl/terrain_feature_classifier_macros.svh */
// ----------------------------------------------------------------------------
// Terrain feature classifier assertion macros
// Concurrent checks clocked on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_FEATURE_CLASSIFIER_MACROS_SVH
`define TERRAIN_FEATURE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define TFC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("terrain_feature_classifier: check failed");

// next-cycle implication
`define TFC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("terrain_feature_classifier: check failed");

`endif

/* rtl/tfc_pkg.sv */
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, register codes and CORDIC constants of the feature classifier.
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam int VS_W       = 24;
    localparam int ST_W       = 15;
    localparam int CT_W       = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_VSCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURV_TOL  = 2'd2;

    localparam logic [VS_W-1:0] VS_RESET = 24'd65536;
    localparam logic [ST_W-1:0] ST_RESET = 15'd256;
    localparam logic [CT_W-1:0] CT_RESET = 31'd7;

    localparam int VS_FRAC  = 16;   // vertical scale is Q8.16
    localparam int TOL_FRAC = 16;   // curvature tolerance is Q15.16

    localparam int NUM_COEF = 5;
    localparam int IDX_XX   = 0;
    localparam int IDX_YY   = 1;
    localparam int IDX_XY   = 2;
    localparam int IDX_X    = 3;
    localparam int IDX_Y    = 4;

    localparam int ITERS   = 22;
    localparam int ANG_W   = 26;
    localparam int CS_W    = 33;
    localparam int XY_W    = 64;
    localparam int XY_HALF = 32;

    localparam logic [ST_W-1:0]        RIGHT_ANGLE = 15'd23040;
    localparam logic [30:0]            GAIN_Q30    = 31'd1768195363;
    localparam logic signed [CS_W-1:0] ROT_RADIUS  = 33'sd1073741824;

    localparam int SCALE_LAT = 2;
    localparam int CURV_LAT  = 5;
    localparam int SLOPE_LAT = ITERS + 3;

    typedef enum logic [2:0] {
        FC_FLAT    = 3'd0,
        FC_PIT     = 3'd1,
        FC_CHANNEL = 3'd2,
        FC_PASS    = 3'd3,
        FC_RIDGE   = 3'd4,
        FC_PEAK    = 3'd5
    } t_feature;

    typedef struct packed {
        logic [VS_W-1:0] vertical_scale;
        logic [ST_W-1:0] slope_tolerance;
        logic [CT_W-1:0] curvature_tolerance;
    } t_cfg;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
        case (idx)
            0:       return 26'sd2949120;
            1:       return 26'sd1740967;
            2:       return 26'sd919879;
            3:       return 26'sd466945;
            4:       return 26'sd234379;
            5:       return 26'sd117304;
            6:       return 26'sd58666;
            7:       return 26'sd29335;
            8:       return 26'sd14668;
            9:       return 26'sd7334;
            10:      return 26'sd3667;
            11:      return 26'sd1833;
            12:      return 26'sd917;
            13:      return 26'sd458;
            14:      return 26'sd229;
            15:      return 26'sd115;
            16:      return 26'sd57;
            17:      return 26'sd29;
            18:      return 26'sd14;
            19:      return 26'sd7;
            20:      return 26'sd4;
            21:      return 26'sd2;
            default: return 26'sd0;
        endcase
    endfunction

endpackage

/* rtl/terrain_feature_classifier.sv */
// ----------------------------------------------------------------------------
// terrain_feature_classifier
// Morphometric feature class of one raster cell from its quadratic
// trend-surface coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the five coefficients and pulse start; an item is taken at
//   each edge with start high and busy low. busy stays low, so one item can
//   enter every cycle, 1 item per cycle sustained.
//   Output: o_feature_class is valid for one cycle with o_strobe. A taken
//   item passes 2 scaling stages, 25 slope stages of which 22 are CORDIC
//   iterations, and 1 output register. Results leave in item order.
//   The receiver cannot hold results off; none is needed, the pipe never
//   stalls.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   ready is always high. Index 0 vertical scale, 1 slope tolerance,
//   2 curvature tolerance, other indexes are ignored. Write only while no
//   item is in flight.
//   Reset (synchronous, i_rst_n low) drops all items in flight and restores
//   the register defaults.
// ----------------------------------------------------------------------------
`include "terrain_feature_classifier_macros.svh"

module terrain_feature_classifier import tfc_pkg::*; #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COEF_WIDTH-1:0] i_coef_xx,
    input  logic signed [COEF_WIDTH-1:0] i_coef_yy,
    input  logic signed [COEF_WIDTH-1:0] i_coef_xy,
    input  logic signed [COEF_WIDTH-1:0] i_coef_x,
    input  logic signed [COEF_WIDTH-1:0] i_coef_y,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_strobe,
    output logic [2:0]                   o_feature_class
);

    localparam int DLY = SLOPE_LAT - CURV_LAT;
    localparam int LAT = SCALE_LAT + SLOPE_LAT + 1;

    t_cfg                         r_cfg;
    logic signed [COEF_WIDTH-1:0] coef_in [NUM_COEF];
    logic signed [COEF_WIDTH-1:0] coef_sc [NUM_COEF];
    logic                         sc_vld;
    logic                         curv_vld;
    t_feature                     curv_slope, curv_level;
    logic                         slope_vld, sloping;

    t_feature                     r_dly_slope [DLY];
    t_feature                     r_dly_level [DLY];
    logic [DLY-1:0]               r_dly_vld;
    t_feature                     r_cls;
    logic                         r_strobe;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign coef_in[IDX_XX] = i_coef_xx;
    assign coef_in[IDX_YY] = i_coef_yy;
    assign coef_in[IDX_XY] = i_coef_xy;
    assign coef_in[IDX_X]  = i_coef_x;
    assign coef_in[IDX_Y]  = i_coef_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vertical_scale      <= VS_RESET;
            r_cfg.slope_tolerance     <= ST_RESET;
            r_cfg.curvature_tolerance <= CT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VSCALE:    r_cfg.vertical_scale      <= i_cfg_data[VS_W-1:0];
                CFG_SLOPE_TOL: r_cfg.slope_tolerance     <= i_cfg_data[ST_W-1:0];
                CFG_CURV_TOL:  r_cfg.curvature_tolerance <= i_cfg_data[CT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tfc_scale #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (start && !busy),
        .i_coef  (coef_in),
        .o_vld   (sc_vld),
        .o_coef  (coef_sc)
    );

    tfc_curv #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_curv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_vld       (sc_vld),
        .i_coef      (coef_sc),
        .o_vld       (curv_vld),
        .o_cls_slope (curv_slope),
        .o_cls_level (curv_level)
    );

    tfc_slope #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_slope (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_vld     (sc_vld),
        .i_d       (coef_sc[IDX_X]),
        .i_e       (coef_sc[IDX_Y]),
        .o_vld     (slope_vld),
        .o_sloping (sloping)
    );

    // curvature classes wait here for the slope decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_vld <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_dly_vld <= {r_dly_vld[DLY-2:0], curv_vld};
            r_strobe  <= slope_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly_slope[0] <= curv_slope;
        r_dly_level[0] <= curv_level;
        for (int i = 1; i < DLY; i++) begin
            r_dly_slope[i] <= r_dly_slope[i-1];
            r_dly_level[i] <= r_dly_level[i-1];
        end
        r_cls <= sloping ? r_dly_slope[DLY-1] : r_dly_level[DLY-1];
    end

    assign o_strobe        = r_strobe;
    assign o_feature_class = r_cls;

    `TFC_ASSERT_NEXT(a_item_latency, start && !busy, ##(LAT-1) o_strobe)
    `TFC_ASSERT_IMP(a_no_phantom, o_strobe, $past(start && !busy, LAT))
    `TFC_ASSERT_IMP(a_branch_align, 1'b1, slope_vld == r_dly_vld[DLY-1])

endmodule

/* rtl/tfc_scale.sv */
// ----------------------------------------------------------------------------
// tfc_scale
// Two-stage coefficient scaling: multiply by vertical scale, floor, saturate.
// ----------------------------------------------------------------------------
module tfc_scale import tfc_pkg::*; #(
    parameter int COEF_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_vld,
    input  logic signed [COEF_WIDTH-1:0] i_coef [NUM_COEF],
    output logic                         o_vld,
    output logic signed [COEF_WIDTH-1:0] o_coef [NUM_COEF]
);

    localparam int PW = COEF_WIDTH + VS_W + 1;
    localparam int SW = PW - VS_FRAC;
    localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    logic signed [PW-1:0]         r_prod [NUM_COEF];
    logic signed [PW-1:0]         n_prod [NUM_COEF];
    logic signed [COEF_WIDTH-1:0] r_coef [NUM_COEF];
    logic signed [COEF_WIDTH-1:0] n_coef [NUM_COEF];
    logic signed [SW-1:0]         shifted [NUM_COEF];
    logic                         r_vld1;
    logic                         r_vld2;

    always_comb begin
        for (int k = 0; k < NUM_COEF; k++) begin
            n_prod[k] = i_coef[k] * $signed({1'b0, i_cfg.vertical_scale});
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_COEF; k++) begin
            shifted[k] = $signed(r_prod[k][PW-1:VS_FRAC]);
            if (shifted[k] > SW'(COEF_MAX)) begin
                n_coef[k] = COEF_MAX;
            end else if (shifted[k] < SW'(COEF_MIN)) begin
                n_coef[k] = COEF_MIN;
            end else begin
                n_coef[k] = shifted[k][COEF_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_coef <= n_coef;
    end

    assign o_vld  = r_vld2;
    assign o_coef = r_coef;

endmodule

/* rtl/tfc_curv.sv */
// ----------------------------------------------------------------------------
// tfc_curv
// Five-stage exact curvature tests: cross-section class for sloping cells and
// principal-curvature class for level cells, both by cross-multiplication.
// ----------------------------------------------------------------------------
module tfc_curv import tfc_pkg::*; #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_vld,
    input  logic signed [COEF_WIDTH-1:0] i_coef [NUM_COEF],
    output logic                         o_vld,
    output t_feature                     o_cls_slope,
    output t_feature                     o_cls_level
);

    localparam int W     = COEF_WIDTH;
    localparam int T_SHL = (FRAC_BITS >= TOL_FRAC) ? FRAC_BITS - TOL_FRAC : 0;
    localparam int T_SHR = (FRAC_BITS < TOL_FRAC) ? TOL_FRAC - FRAC_BITS : 0;
    localparam int TW    = CT_W + T_SHL;
    localparam int UW    = ((TW + 1 > W + 1) ? TW + 1 : W + 1) + 1;
    localparam int QW    = 2 * W + 3;
    localparam int SQW   = 2 * UW;
    localparam int CW    = ((QW > SQW) ? QW : SQW) + 1;
    localparam int PPW   = 2 * W + 2;
    localparam int NSW   = PPW + 2;
    localparam int NW    = NSW + W + 2;
    localparam int TDPW  = TW + W + 3;
    localparam int TDW   = TDPW + W + 1;
    localparam int LW    = ((NW > TDW) ? NW : TDW) + 1;

    logic [TW-1:0]        tol_q;
    logic signed [TW:0]   tol_s;

    // stage 1
    logic signed [2*W-1:0] r1_dd, r1_ee, r1_de;
    logic signed [W-1:0]   r1_a, r1_b, r1_c;
    logic signed [W:0]     r1_amb;
    logic signed [UW-1:0]  r1_u, r1_v;
    // stage 2
    logic signed [PPW-1:0] r2_bddl, r2_bddh, r2_aeel, r2_aeeh, r2_cdel, r2_cdeh;
    logic signed [2*W:0]   r2_den;
    logic signed [QW-1:0]  r2_asq, r2_csq;
    logic signed [SQW-1:0] r2_usq, r2_vsq;
    logic                  r2_uneg, r2_vneg;
    // stage 3
    logic signed [NSW-1:0]  r3_nlo, r3_nhi;
    logic signed [QW-1:0]   r3_q;
    logic signed [TDPW-1:0] r3_tdl, r3_tdh;
    logic signed [SQW-1:0]  r3_usq, r3_vsq;
    logic                   r3_uneg, r3_vneg;
    // stage 4
    logic signed [NW-1:0]  n4_num, r4_num;
    logic signed [TDW-1:0] n4_td, r4_td;
    t_feature              n4_level, r4_level;
    logic                  max_pos, max_neg, min_pos, min_neg;
    // stage 5
    logic signed [LW-1:0]  lhs2, td_ext;
    t_feature              n5_slope, r5_slope, r5_level;

    logic [CURV_LAT-1:0]   r_vld;

    always_comb begin
        tol_q = (TW'(i_cfg.curvature_tolerance) << T_SHL) >> T_SHR;
        tol_s = $signed({1'b0, tol_q});
    end

    always_comb begin
        max_pos = r3_uneg || (CW'(r3_q) > CW'(r3_usq));
        max_neg = r3_vneg && (CW'(r3_q) < CW'(r3_vsq));
        min_pos = r3_uneg && (CW'(r3_q) < CW'(r3_usq));
        min_neg = r3_vneg || (CW'(r3_q) > CW'(r3_vsq));
        if (max_pos) begin
            n4_level = min_pos ? FC_PEAK : (min_neg ? FC_PASS : FC_RIDGE);
        end else if (max_neg) begin
            n4_level = min_neg ? FC_PIT : FC_FLAT;
        end else begin
            n4_level = min_neg ? FC_CHANNEL : FC_FLAT;
        end
        n4_num = (NW'(r3_nhi) <<< W) + NW'(r3_nlo);
        n4_td  = (TDW'(r3_tdh) <<< W) + TDW'(r3_tdl);
    end

    // cross section = -2*num / den against +/- t
    always_comb begin
        lhs2   = LW'(r4_num) <<< 1;
        td_ext = LW'(r4_td);
        if (lhs2 < -td_ext) begin
            n5_slope = FC_RIDGE;
        end else if (lhs2 > td_ext) begin
            n5_slope = FC_CHANNEL;
        end else begin
            n5_slope = FC_FLAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CURV_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dd  <= i_coef[IDX_X] * i_coef[IDX_X];
        r1_ee  <= i_coef[IDX_Y] * i_coef[IDX_Y];
        r1_de  <= i_coef[IDX_X] * i_coef[IDX_Y];
        r1_a   <= i_coef[IDX_XX];
        r1_b   <= i_coef[IDX_YY];
        r1_c   <= i_coef[IDX_XY];
        r1_amb <= (W+1)'(i_coef[IDX_XX]) - (W+1)'(i_coef[IDX_YY]);
        r1_u   <= UW'(tol_s) + UW'(i_coef[IDX_XX]) + UW'(i_coef[IDX_YY]);
        r1_v   <= UW'(tol_s) - UW'(i_coef[IDX_XX]) - UW'(i_coef[IDX_YY]);

        r2_bddl <= r1_b * $signed({1'b0, r1_dd[W-1:0]});
        r2_bddh <= r1_b * $signed({1'b0, r1_dd[2*W-1:W]});
        r2_aeel <= r1_a * $signed({1'b0, r1_ee[W-1:0]});
        r2_aeeh <= r1_a * $signed({1'b0, r1_ee[2*W-1:W]});
        r2_cdel <= r1_c * $signed({1'b0, r1_de[W-1:0]});
        r2_cdeh <= r1_c * $signed(r1_de[2*W-1:W]);
        r2_den  <= (2*W+1)'(r1_dd) + (2*W+1)'(r1_ee);
        r2_asq  <= r1_amb * r1_amb;
        r2_csq  <= r1_c * r1_c;
        r2_usq  <= r1_u * r1_u;
        r2_vsq  <= r1_v * r1_v;
        r2_uneg <= r1_u[UW-1];
        r2_vneg <= r1_v[UW-1];

        r3_nlo  <= NSW'(r2_bddl) + NSW'(r2_aeel) - NSW'(r2_cdel);
        r3_nhi  <= NSW'(r2_bddh) + NSW'(r2_aeeh) - NSW'(r2_cdeh);
        r3_q    <= r2_asq + r2_csq;
        r3_tdl  <= tol_s * $signed({1'b0, r2_den[W-1:0]});
        r3_tdh  <= tol_s * $signed({1'b0, r2_den[2*W:W]});
        r3_usq  <= r2_usq;
        r3_vsq  <= r2_vsq;
        r3_uneg <= r2_uneg;
        r3_vneg <= r2_vneg;

        r4_num   <= n4_num;
        r4_td    <= n4_td;
        r4_level <= n4_level;

        r5_slope <= n5_slope;
        r5_level <= r4_level;
    end

    assign o_vld       = r_vld[CURV_LAT-1];
    assign o_cls_slope = r5_slope;
    assign o_cls_level = r5_level;

endmodule

/* rtl/tfc_slope.sv */
// ----------------------------------------------------------------------------
// tfc_slope
// Slope test: pipelined CORDIC, one iteration per stage, vectoring the
// gradient and rotating the tolerance angle side by side, then a two-stage
// cross-multiplied compare.
// ----------------------------------------------------------------------------
module tfc_slope import tfc_pkg::*; #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_vld,
    input  logic signed [COEF_WIDTH-1:0] i_d,
    input  logic signed [COEF_WIDTH-1:0] i_e,
    output logic                         o_vld,
    output logic                         o_sloping
);

    localparam int SH    = 61 - COEF_WIDTH;
    localparam int EX    = FRAC_BITS + SH - 30;
    localparam int LSH   = (EX < 0) ? -EX : 0;
    localparam int RSH   = (EX > 0) ? EX : 0;
    localparam int PH_W  = XY_HALF + CS_W;
    localparam int PL_W  = XY_HALF + 1 + CS_W;
    localparam int LHS_W = PL_W + XY_HALF;
    localparam int RHS_W = 32 + CS_W;
    localparam int CMP_W = ((LHS_W + LSH > RHS_W + RSH) ? LHS_W + LSH : RHS_W + RSH) + 1;

    logic signed [XY_W-1:0]  r_x [ITERS+1];
    logic signed [XY_W-1:0]  r_y [ITERS+1];
    logic signed [CS_W-1:0]  r_c [ITERS+1];
    logic signed [CS_W-1:0]  r_s [ITERS+1];
    logic signed [ANG_W-1:0] r_z [ITERS+1];
    logic signed [XY_W-1:0]  n_x [ITERS+1];
    logic signed [XY_W-1:0]  n_y [ITERS+1];
    logic signed [CS_W-1:0]  n_c [ITERS+1];
    logic signed [CS_W-1:0]  n_s [ITERS+1];
    logic signed [ANG_W-1:0] n_z [ITERS+1];
    logic [ITERS:0]          r_vld;
    logic [ITERS:0]          r_zero;

    logic signed [COEF_WIDTH:0] d_ext, d_abs;
    logic signed [XY_W-1:0]     x_fin;

    logic signed [PH_W-1:0]  r_phi;
    logic signed [PL_W-1:0]  r_plo;
    logic signed [RHS_W-1:0] r_rhs;
    logic                    r_m1_cpos, r_m1_spos, r_m1_zero, r_m1_vld;
    logic signed [LHS_W-1:0] lhs;
    logic signed [CMP_W-1:0] lhs_cmp, rhs_cmp;
    logic                    n_sloping, r_sloping, r_m2_vld;

    always_comb begin
        d_ext  = (COEF_WIDTH+1)'(i_d);
        d_abs  = d_ext[COEF_WIDTH] ? -d_ext : d_ext;
        n_x[0] = XY_W'(d_abs) <<< SH;
        n_y[0] = XY_W'(i_e) <<< SH;
        n_c[0] = ROT_RADIUS;
        n_s[0] = '0;
        n_z[0] = $signed(ANG_W'({i_cfg.slope_tolerance, 8'd0}));
        for (int i = 0; i < ITERS; i++) begin
            if (r_y[i] >= 0) begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
            end else begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
            end
            if (r_z[i] >= 0) begin
                n_c[i+1] = r_c[i] - (r_s[i] >>> i);
                n_s[i+1] = r_s[i] + (r_c[i] >>> i);
                n_z[i+1] = r_z[i] - atan_deg(i);
            end else begin
                n_c[i+1] = r_c[i] + (r_s[i] >>> i);
                n_s[i+1] = r_s[i] - (r_c[i] >>> i);
                n_z[i+1] = r_z[i] + atan_deg(i);
            end
        end
    end

    // magnitude * cos > gain * sin, brought to one scale
    always_comb begin
        x_fin   = r_x[ITERS];
        lhs     = (LHS_W'(r_phi) <<< XY_HALF) + LHS_W'(r_plo);
        lhs_cmp = CMP_W'(lhs) <<< LSH;
        rhs_cmp = CMP_W'(r_rhs) <<< RSH;
        n_sloping = !r_m1_zero && (i_cfg.slope_tolerance < RIGHT_ANGLE)
                    && ((i_cfg.slope_tolerance == '0)
                        || (r_m1_cpos && (!r_m1_spos || (lhs_cmp > rhs_cmp))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
        end else begin
            r_vld    <= {r_vld[ITERS-1:0], i_vld};
            r_m1_vld <= r_vld[ITERS];
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= ITERS; i++) begin
            r_x[i] <= n_x[i];
            r_y[i] <= n_y[i];
            r_c[i] <= n_c[i];
            r_s[i] <= n_s[i];
            r_z[i] <= n_z[i];
        end
        r_zero    <= {r_zero[ITERS-1:0], (i_d == '0) && (i_e == '0)};
        r_phi     <= $signed(x_fin[XY_W-1:XY_HALF]) * r_c[ITERS];
        r_plo     <= $signed({1'b0, x_fin[XY_HALF-1:0]}) * r_c[ITERS];
        r_rhs     <= $signed({1'b0, GAIN_Q30}) * r_s[ITERS];
        r_m1_cpos <= r_c[ITERS] > 0;
        r_m1_spos <= r_s[ITERS] > 0;
        r_m1_zero <= r_zero[ITERS];
        r_sloping <= n_sloping;
    end

    assign o_vld     = r_m2_vld;
    assign o_sloping = r_sloping;

endmodule
